// ===== src/bbd_pkg.sv =====
// Shared types, constants and averaging function for the Bayer demosaic block.
package bbd_pkg;

    localparam int MAX_LINE_WIDTH = 4096;
    localparam int MAX_FRAME_HEIGHT = 4096;
    localparam int ADDR_W = $clog2(MAX_LINE_WIDTH);
    localparam int DIM_W = 13;
    localparam int PIX_W = 8;
    localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [DIM_W-1:0] DIM_MIN = 13'd2;
    localparam logic [DIM_W-1:0] WIDTH_MAX = 13'd4096;
    localparam logic [DIM_W-1:0] HEIGHT_MAX = 13'd4096;
    localparam logic [10:0] RECIP_THREE = 11'd683;

    localparam logic CFG_FRAME_WIDTH = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic shift;
        logic calc;
    } cmd_t;

    typedef struct packed {
        logic produce;
    } sts_t;

    function automatic logic [PIX_W-1:0] avg4(
        input logic [3:0] ok,
        input logic [PIX_W-1:0] v0,
        input logic [PIX_W-1:0] v1,
        input logic [PIX_W-1:0] v2,
        input logic [PIX_W-1:0] v3
    );
        logic [9:0] sum;
        logic [20:0] prod;
        logic [PIX_W-1:0] res;
        sum = (ok[0] ? {2'b00, v0} : 10'd0) + (ok[1] ? {2'b00, v1} : 10'd0)
            + (ok[2] ? {2'b00, v2} : 10'd0) + (ok[3] ? {2'b00, v3} : 10'd0);
        prod = {11'd0, sum} * {10'd0, RECIP_THREE};
        case ($countones(ok))
            1: res = sum[PIX_W-1:0];
            2: res = sum[PIX_W:1];
            3: res = prod[18:11];
            4: res = sum[PIX_W+1:2];
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== src/bayer_bilinear_demosaic.sv =====
// Top level of the streaming bilinear Bayer demosaic.
//
//   channel   direction   signals
//   input     in          in_valid, in_ready, raw_sample, drain
//   output    out         out_valid, out_ready, red_value, green_value, blue_value, frame_last
//   config    in          cfg_write_en, cfg_index, cfg_data
//
// Each item passes through capture with line store read, window shift with
// line store write, and interpolation; an item that produces a result then waits
// until it is taken. The line store read latency sets the sequence.
// Reset clears the counters, the window and the controller; line stores are not cleared.
// A stalled output holds the block until the item is taken.
module bayer_bilinear_demosaic (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic                             cfg_index,
    input  logic [bbd_pkg::DIM_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [bbd_pkg::PIX_W-1:0]        raw_sample,
    input  logic                             drain,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bbd_pkg::PIX_W-1:0]        red_value,
    output logic [bbd_pkg::PIX_W-1:0]        green_value,
    output logic [bbd_pkg::PIX_W-1:0]        blue_value,
    output logic                             frame_last
);

    bbd_pkg::cmd_t cmd;
    bbd_pkg::sts_t sts;

    bbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bbd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .raw_sample   (raw_sample),
        .drain        (drain),
        .cmd          (cmd),
        .sts          (sts),
        .red_value    (red_value),
        .green_value  (green_value),
        .blue_value   (blue_value),
        .frame_last   (frame_last)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("new item taken before the previous one finished");

    a_out_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.calc) && $past(sts.produce))
        else $error("result shown without a calculation");

endmodule

// ===== src/bbd_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
module bbd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  bbd_pkg::sts_t sts,
    output bbd_pkg::cmd_t cmd
);

    bbd_pkg::state_t state_reg;
    bbd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            bbd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = bbd_pkg::ST_READ;
                end
            end
            bbd_pkg::ST_READ:
            begin
                cmd.shift = 1'b1;
                state_next = bbd_pkg::ST_CALC;
            end
            bbd_pkg::ST_CALC:
            begin
                cmd.calc = 1'b1;
                state_next = sts.produce ? bbd_pkg::ST_OUT : bbd_pkg::ST_IDLE;
            end
            bbd_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = bbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bbd_datapath.sv =====
// Datapath with line stores, 3x3 window, position counters and color interpolation.
module bbd_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic                             cfg_index,
    input  logic [bbd_pkg::DIM_W-1:0]        cfg_data,
    input  logic [bbd_pkg::PIX_W-1:0]        raw_sample,
    input  logic                             drain,
    input  bbd_pkg::cmd_t                    cmd,
    output bbd_pkg::sts_t                    sts,
    output logic [bbd_pkg::PIX_W-1:0]        red_value,
    output logic [bbd_pkg::PIX_W-1:0]        green_value,
    output logic [bbd_pkg::PIX_W-1:0]        blue_value,
    output logic                             frame_last
);

    logic [bbd_pkg::DIM_W-1:0] width_cfg_reg;
    logic [bbd_pkg::DIM_W-1:0] height_cfg_reg;
    logic [bbd_pkg::ADDR_W-1:0] col_reg;
    logic [bbd_pkg::DIM_W-1:0] row_reg;
    logic [bbd_pkg::PIX_W-1:0] sample_reg;
    logic [bbd_pkg::PIX_W-1:0] upper_rd_reg;
    logic [bbd_pkg::PIX_W-1:0] middle_rd_reg;
    logic [bbd_pkg::PIX_W-1:0] win_reg [3][3];
    logic [bbd_pkg::PIX_W-1:0] upper_mem [bbd_pkg::MAX_LINE_WIDTH];
    logic [bbd_pkg::PIX_W-1:0] middle_mem [bbd_pkg::MAX_LINE_WIDTH];

    logic [bbd_pkg::DIM_W-1:0] w;
    logic [bbd_pkg::DIM_W-1:0] h;
    logic [bbd_pkg::DIM_W-1:0] col_ext;
    logic [bbd_pkg::DIM_W-1:0] cx;
    logic [bbd_pkg::DIM_W-1:0] cy;
    logic [bbd_pkg::DIM_W:0] cx_inc;
    logic [bbd_pkg::DIM_W:0] cy_inc;
    logic have;
    logic lf;
    logic rt;
    logic tp;
    logic bt;
    logic [bbd_pkg::PIX_W-1:0] avg_h;
    logic [bbd_pkg::PIX_W-1:0] avg_v;
    logic [bbd_pkg::PIX_W-1:0] avg_d;
    logic [bbd_pkg::PIX_W-1:0] avg_x;
    logic [bbd_pkg::PIX_W-1:0] red_next;
    logic [bbd_pkg::PIX_W-1:0] green_next;
    logic [bbd_pkg::PIX_W-1:0] blue_next;

    always_comb
    begin
        if (width_cfg_reg < bbd_pkg::DIM_MIN)
            w = bbd_pkg::DIM_MIN;
        else if (width_cfg_reg > bbd_pkg::WIDTH_MAX)
            w = bbd_pkg::WIDTH_MAX;
        else
            w = width_cfg_reg;
        if (height_cfg_reg < bbd_pkg::DIM_MIN)
            h = bbd_pkg::DIM_MIN;
        else if (height_cfg_reg > bbd_pkg::HEIGHT_MAX)
            h = bbd_pkg::HEIGHT_MAX;
        else
            h = height_cfg_reg;
    end

    assign col_ext = {1'b0, col_reg};

    always_comb
    begin
        have = 1'b0;
        cx = '0;
        cy = '0;
        if (col_ext != '0 && row_reg != '0)
        begin
            have = 1'b1;
            cx = col_ext - 13'd1;
            cy = row_reg - 13'd1;
        end
        else if (col_ext == '0 && row_reg >= 13'd2)
        begin
            have = 1'b1;
            cx = w - 13'd1;
            cy = row_reg - 13'd2;
        end
    end

    assign cx_inc = {1'b0, cx} + 14'd1;
    assign cy_inc = {1'b0, cy} + 14'd1;
    assign lf = cx != '0;
    assign rt = cx_inc < {1'b0, w};
    assign tp = cy != '0;
    assign bt = cy_inc < {1'b0, h};
    assign sts.produce = have && (cx < w) && (cy < h);

    assign avg_h = bbd_pkg::avg4({2'b00, rt, lf}, win_reg[1][0], win_reg[1][2], '0, '0);
    assign avg_v = bbd_pkg::avg4({2'b00, bt, tp}, win_reg[0][1], win_reg[2][1], '0, '0);
    assign avg_d = bbd_pkg::avg4({bt && rt, bt && lf, tp && rt, tp && lf},
        win_reg[0][0], win_reg[0][2], win_reg[2][0], win_reg[2][2]);
    assign avg_x = bbd_pkg::avg4({bt, rt, lf, tp},
        win_reg[0][1], win_reg[1][0], win_reg[1][2], win_reg[2][1]);

    always_comb
    begin
        if (cx[0] == cy[0])
        begin
            green_next = win_reg[1][1];
            red_next = cy[0] ? avg_h : avg_v;
            blue_next = cy[0] ? avg_v : avg_h;
        end
        else if (cy[0])
        begin
            red_next = win_reg[1][1];
            green_next = avg_x;
            blue_next = avg_d;
        end
        else
        begin
            blue_next = win_reg[1][1];
            green_next = avg_x;
            red_next = avg_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg <= bbd_pkg::WIDTH_RESET;
            height_cfg_reg <= bbd_pkg::HEIGHT_RESET;
            col_reg <= '0;
            row_reg <= '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == bbd_pkg::CFG_FRAME_WIDTH)
                    width_cfg_reg <= cfg_data;
                else
                    height_cfg_reg <= cfg_data;
            end
            if (cmd.shift)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= upper_rd_reg;
                win_reg[1][2] <= middle_rd_reg;
                win_reg[2][2] <= sample_reg;
            end
            if (cmd.calc)
            begin
                if ({1'b0, row_reg} >= {1'b0, h} + 14'd1)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if ({1'b0, col_ext} + 14'd1 >= {1'b0, w})
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 13'd1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= drain ? '0 : raw_sample;
            upper_rd_reg <= upper_mem[col_reg];
            middle_rd_reg <= middle_mem[col_reg];
        end
        if (cmd.shift)
        begin
            upper_mem[col_reg] <= middle_rd_reg;
            middle_mem[col_reg] <= sample_reg;
        end
        if (cmd.calc && sts.produce)
        begin
            red_value <= red_next;
            green_value <= green_next;
            blue_value <= blue_next;
            frame_last <= (cx == w - 13'd1) && (cy == h - 13'd1);
        end
    end

endmodule
